// ===== hw/rtl/fwdf_pkg.sv =====
// Shared types and character constants for the decimal field formatter.
`timescale 1ns / 1ps
`default_nettype none

package fwdf_pkg;

  // ASCII codes used in the field
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  // Divide by ten: q = (x * RECIP10) >> RECIP10_SHIFT, exact for x < 81920
  localparam logic [15:0] RECIP10       = 16'd52429;
  localparam int          RECIP10_SHIFT = 19;

  localparam int MAG_W   = 17;
  localparam int WIDTH_W = 4;

  typedef struct packed {
    logic signed [15:0] value;
    logic [3:0]         width;
  } fwdf_in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic [2:0] position;
    logic       last;
  } fwdf_out_t;

  // Classified job handed from the front end to the digit engine
  typedef struct packed {
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [WIDTH_W-1:0] w;
  } fwdf_job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fwdf_front.sv =====
// Front end: accepts items, takes the magnitude and clamps the field width.
`timescale 1ns / 1ps
`default_nettype none

module fwdf_front
  import fwdf_pkg::*;
#(
  parameter int MAX_DIGITS = 8
) (
  input  wire fwdf_in_t  req,
  input  wire            req_valid,
  output logic           req_ready,
  input  wire            q_full,
  output logic           push,
  output fwdf_job_t      job
);

  localparam logic [WIDTH_W-1:0] WMAX = WIDTH_W'(MAX_DIGITS);

  logic raw_neg;

  assign req_ready = !q_full;
  assign push      = req_valid && !q_full;
  assign raw_neg   = req.value[15];

  // Sign, 17-bit magnitude and clamped width
  always_comb begin
    job.neg = raw_neg;
    if (raw_neg) begin
      job.mag = 17'h10000 - {1'b0, req.value};
    end else begin
      job.mag = {1'b0, req.value};
    end
    priority if (req.width == '0) begin
      job.w = WIDTH_W'(1);
    end else if (req.width > WMAX) begin
      job.w = WMAX;
    end else begin
      job.w = req.width;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fwdf_queue.sv =====
// Two-entry job queue between the front end and the digit engine.
`timescale 1ns / 1ps
`default_nettype none

module fwdf_queue
  import fwdf_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        push,
  input  wire fwdf_job_t push_job,
  output logic       full,
  input  wire        pop,
  output logic       q_valid,
  output fwdf_job_t  q_job
);

  fwdf_job_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_job   = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fwdf_back.sv =====
// Digit engine: one decimal digit per cycle right to left, then streams the field.
`timescale 1ns / 1ps
`default_nettype none

module fwdf_back
  import fwdf_pkg::*;
#(
  parameter int MAX_DIGITS = 8
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        q_valid,
  input  wire fwdf_job_t q_job,
  output logic       pop,
  output logic       rsp_valid,
  input  wire        rsp_ready,
  output fwdf_out_t  rsp
);

  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state;
  logic [IW-1:0]      idx;
  logic [WIDTH_W-1:0] w;
  logic               neg;
  logic               placed;
  logic               ovf;
  logic [MAG_W-1:0]   mag;
  logic [7:0]         text [MAX_DIGITS];

  logic [32:0]        prod;
  logic [MAG_W-1:0]   quo;
  logic [MAG_W-1:0]   rem;
  logic               at_right;
  logic               at_end;
  logic [7:0]         conv_char;
  logic               place_sign;
  logic               emit_go;

  // Divide by ten through the reciprocal, remainder by shift-add
  assign prod = 33'(mag) * 33'(RECIP10);
  assign quo  = MAG_W'(prod >> RECIP10_SHIFT);
  assign rem  = mag - ((quo << 3) + (quo << 1));

  assign at_right = (WIDTH_W'(idx) == w - WIDTH_W'(1));
  assign at_end   = (idx == '0);
  assign pop      = (state == ST_IDLE) && q_valid;
  assign emit_go  = (state == ST_EMIT) && (!rsp_valid || rsp_ready);

  // Character for the current position while converting
  always_comb begin
    place_sign = 1'b0;
    priority if (at_right || (mag != '0)) begin
      conv_char = CH_ZERO + 8'(rem[3:0]);
    end else if (neg && !placed) begin
      conv_char  = CH_MINUS;
      place_sign = 1'b1;
    end else begin
      conv_char = CH_SPACE;
    end
  end

  // Field buffer
  always_ff @(posedge clk) begin
    if (state == ST_CONV) begin
      text[idx] <= conv_char;
    end
  end

  // Sequencer and job registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      idx    <= '0;
      placed <= 1'b0;
      ovf    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            idx    <= IW'(q_job.w - WIDTH_W'(1));
            placed <= 1'b0;
            state  <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (place_sign) begin
            placed <= 1'b1;
          end
          if (at_end) begin
            ovf   <= (quo != '0);
            state <= ST_EMIT;
          end else begin
            idx <= idx - IW'(1);
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            if (at_right) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx + IW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Job payload, no reset needed
  always_ff @(posedge clk) begin
    if (pop) begin
      mag <= q_job.mag;
      neg <= q_job.neg;
      w   <= q_job.w;
    end else if (state == ST_CONV) begin
      mag <= quo;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      rsp.char_code <= (at_end && ovf) ? CH_STAR : text[idx];
      rsp.position  <= 3'(idx);
      rsp.last      <= at_right;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_width_decimal_formatter.sv =====
// Top level: right-aligned signed decimal field, one ASCII character per item out.
// Each item passes through the single digit engine as w divide-by-ten steps, then w output
// beats (w = width); a two-entry queue lets the front keep taking items until it is full.
// Reset: synchronous, active high; clears queue pointers and fill count, sequencer and output valid.
`timescale 1ns / 1ps
`default_nettype none

module fixed_width_decimal_formatter
  import fwdf_pkg::*;
#(
  parameter int MAX_DIGITS = 8
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        req_valid,
  output logic       req_ready,
  input  wire fwdf_in_t req,
  output logic       rsp_valid,
  input  wire        rsp_ready,
  output fwdf_out_t  rsp
);

  logic      push;
  logic      q_full;
  logic      pop;
  logic      q_valid;
  fwdf_job_t push_job;
  fwdf_job_t q_job;

  fwdf_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  fwdf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  fwdf_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fwdf_checker.sv =====
// Port-level checks for the decimal field formatter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fwdf_checker
  import fwdf_pkg::*;
(
  input wire            clk,
  input wire            rst,
  input wire            rsp_valid,
  input wire            rsp_ready,
  input wire fwdf_out_t rsp
);

  logic [2:0] exp_pos;

  // Expected position of the next output character
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_pos <= '0;
    end else if (rsp_valid && rsp_ready) begin
      exp_pos <= rsp.last ? 3'd0 : exp_pos + 3'd1;
    end
  end

  // A stalled output item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("output item changed while stalled");

  // Characters run left to right from position 0 and restart after last
  a_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.position == exp_pos)
    else $error("output position out of order");

  // Only digits, space, minus or star appear
  a_char: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.char_code == CH_SPACE) || (rsp.char_code == CH_MINUS) ||
                  (rsp.char_code == CH_STAR) ||
                  ((rsp.char_code >= CH_ZERO) && (rsp.char_code <= CH_ZERO + 8'd9)))
    else $error("illegal character code");

  // Star only ever shows in the leftmost position
  a_star: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.char_code == CH_STAR) |-> rsp.position == 3'd0)
    else $error("overflow mark away from position 0");

  // Nothing comes out in the cycle after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("output valid right after reset");

endmodule

bind fixed_width_decimal_formatter fwdf_checker u_fwdf_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the fixed-width decimal field formatter.
`timescale 1ns / 1ps

module tb;
  import fwdf_pkg::*;

  localparam int FIELD_MAX      = 8;
  localparam int RANDOM_ITEMS   = 147;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 24;

  typedef struct packed {
    fwdf_in_t fmt;
    logic     drain;  // hold this item until every pending character is back
  } fmt_req_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  fwdf_in_t  req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  fwdf_out_t rsp;

  fmt_req_t  fmt_reqs_q[$];
  fwdf_out_t chars_due_q[$];
  int        chars_due = 0;
  int        err_cnt = 0;
  int        idle_cycles = 0;
  int        tx_gap = 0;
  int        rx_stall = 0;
  logic      quiet_tx = 1'b0;
  logic      quiet_rx = 1'b0;

  fixed_width_decimal_formatter dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Mostly short gaps, a few long ones; none during a quiet stretch
  function automatic int pick_gap(input logic quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Expected characters of one formatted field, left to right
  function automatic void queue_field_chars(input fwdf_in_t item);
    logic [7:0]  text [FIELD_MAX];
    logic        neg;
    logic [16:0] mag;
    int          w;
    int          k;
    int          m;
    fwdf_out_t   c;
    neg = item.value[15];
    mag = neg ? (17'h10000 - {1'b0, item.value}) : {1'b0, item.value};
    w = item.width;
    if (w == 0) w = 1;
    if (w > FIELD_MAX) w = FIELD_MAX;
    // units digit always shows
    text[w-1] = CH_ZERO + 8'(mag % 10);
    mag = mag / 10;
    for (k = w - 2; k >= 0; k--) begin
      if (mag != 0) begin
        text[k] = CH_ZERO + 8'(mag % 10);
        mag = mag / 10;
      end else begin
        text[k] = CH_SPACE;
      end
    end
    // sign goes in the blank left of the top digit, dropped if none
    if (neg) begin
      for (m = 0; m < w; m++)
        if (text[m] != CH_SPACE) break;
      if (m > 0 && m < w) text[m-1] = CH_MINUS;
    end
    // leftover digits mark the field as overflowed
    if (mag != 0) text[0] = CH_STAR;
    for (k = 0; k < w; k++) begin
      c.char_code = text[k];
      c.position  = 3'(k);
      c.last      = (k == w - 1);
      chars_due_q.push_back(c);
    end
  endfunction

  task automatic add_item(input int v, input int w, input logic drain);
    fmt_req_t it;
    it.fmt.value = 16'(v);
    it.fmt.width = 4'(w);
    it.drain     = drain;
    fmt_reqs_q.push_back(it);
  endtask

  function automatic int rand_value();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 65535);
      1: v = $urandom_range(0, 999);
      2: v = (10 ** $urandom_range(0, 4)) + $urandom_range(0, 2) - 1;
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32767;
          1: v = 32768;
          2: v = 0;
          default: v = 65535;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Quiet stretches with no idling on either side
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) quiet_tx <= ~quiet_tx;
    if ($urandom_range(0, 199) == 0) quiet_rx <= ~quiet_rx;
  end

  // Request driver
  always @(posedge clk) begin
    fmt_req_t it;
    if (rst) begin
      req_valid <= 1'b0;
      tx_gap = 0;
    end else if (!req_valid || req_ready) begin
      if (req_valid) tx_gap = pick_gap(quiet_tx);
      if (tx_gap != 0) begin
        tx_gap--;
        req_valid <= 1'b0;
      end else if (fmt_reqs_q.size() == 0) begin
        req_valid <= 1'b0;
      end else if (fmt_reqs_q[0].drain && (req_valid || chars_due != 0)) begin
        req_valid <= 1'b0;
      end else begin
        it = fmt_reqs_q.pop_front();
        req       <= it.fmt;
        req_valid <= 1'b1;
      end
    end
  end

  // Response stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rx_stall = 0;
    end else if (rx_stall != 0) begin
      rx_stall--;
      rsp_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      rx_stall = pick_gap(quiet_rx);
      rsp_ready <= (rx_stall == 0);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Monitor: predict on request, check each character
  always @(posedge clk) begin
    fwdf_out_t e;
    if (!rst) begin
      if (req_valid && req_ready) queue_field_chars(req);
      if (rsp_valid && rsp_ready) begin
        if (chars_due_q.size() == 0) begin
          report_error($sformatf("unexpected char %h pos %0d last %b",
                                 rsp.char_code, rsp.position, rsp.last));
        end else begin
          e = chars_due_q.pop_front();
          if (rsp.char_code !== e.char_code)
            report_error($sformatf("char_code got %h exp %h at pos %0d",
                                   rsp.char_code, e.char_code, e.position));
          if (rsp.position !== e.position)
            report_error($sformatf("position got %0d exp %0d",
                                   rsp.position, e.position));
          if (rsp.last !== e.last)
            report_error($sformatf("last got %b exp %b at pos %0d",
                                   rsp.last, e.last, e.position));
        end
      end
      chars_due <= chars_due_q.size();
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("fixed_width_decimal_formatter verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int w;
    // directed: extremes, width clamping, sign placement, overflow
    add_item(0, 1, 1'b0);
    add_item(0, 8, 1'b0);
    add_item(42, 0, 1'b0);
    add_item(32767, 15, 1'b0);
    add_item(32767, 5, 1'b0);
    add_item(32767, 4, 1'b0);
    add_item(-32768, 8, 1'b0);
    add_item(-32768, 6, 1'b0);
    add_item(-32768, 5, 1'b0);
    add_item(-32768, 4, 1'b0);
    add_item(-1, 1, 1'b0);
    add_item(-1, 2, 1'b0);
    add_item(-12, 2, 1'b0);
    add_item(-12, 3, 1'b0);
    add_item(-5, 9, 1'b0);
    add_item(1, 8, 1'b0);
    add_item(99, 2, 1'b0);
    add_item(100, 2, 1'b0);
    add_item(-99, 3, 1'b0);
    add_item(-100, 3, 1'b0);
    add_item(12345, 12, 1'b0);
    add_item(-999, 4, 1'b0);
    add_item(10, 7, 1'b0);
    // random part; every so often let the field drain completely first
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 4) == 0) w = $urandom_range(0, 15);
      else w = $urandom_range(1, FIELD_MAX);
      add_item(rand_value(), w, (i % 40) == 0);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (fmt_reqs_q.size() != 0 || req_valid || chars_due != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (err_cnt == 0) begin
      $display("fixed_width_decimal_formatter verification clean");
    end else begin
      $display("fixed_width_decimal_formatter verification failed");
    end
    $finish;
  end

endmodule

// ===== fixed_width_decimal_formatter.f =====
hw/rtl/fwdf_pkg.sv
hw/rtl/fwdf_front.sv
hw/rtl/fwdf_queue.sv
hw/rtl/fwdf_back.sv
hw/rtl/fixed_width_decimal_formatter.sv
hw/rtl/fwdf_checker.sv
test/tb.sv
